FILE: design/jcfp_pkg.sv
// Shared types, constants and helpers for the joint command frame packer.
`timescale 1ns / 1ps
package jcfp_pkg;

  localparam int JOINTS      = 6;
  localparam int SLOW_JOINTS = 3;   // joints below this take torque * 1/4
  localparam int IDX_W       = 3;
  localparam int DATA_W      = 32;
  localparam int GAIN_W      = 31;
  localparam int LANES       = 5;
  localparam int CODE_W      = 16;  // widest code, one divider stage per bit
  localparam int OFF_W       = 36;  // signed offsets and spans
  localparam int DIV_W       = 52;  // dividend and shifted divisor
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_W        = 168;
  localparam int OUT_W       = 80;
  localparam int FRAME_ID_W  = 9;
  localparam logic [FRAME_ID_W-1:0] FRAME_ID_BASE = 9'h15A;

  // lane order
  localparam int L_POS = 0;
  localparam int L_VEL = 1;
  localparam int L_KP  = 2;
  localparam int L_KD  = 3;
  localparam int L_TQ  = 4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_VEL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_KP  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_KD  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TQ  = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] R_POS_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] R_POS_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] R_VEL_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] R_VEL_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] R_STIFF_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] R_DAMP_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] R_TQ_MIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] R_TQ_MAX    = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] pos_min;
    logic [DATA_W-1:0] pos_max;
    logic [DATA_W-1:0] vel_min;
    logic [DATA_W-1:0] vel_max;
    logic [GAIN_W-1:0] stiff_max;
    logic [GAIN_W-1:0] damp_max;
    logic [DATA_W-1:0] torque_min;
    logic [DATA_W-1:0] torque_max;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [STATUS_W-1:0] status;
    logic [LANES-1:0]    zero;   // code forced to zero
    logic                tsat;   // torque code saturates high
  } meta_t;

  // code width of each lane
  function automatic int lane_bits(input int lane);
    int b;
    case (lane)
      L_POS:   b = 16;
      L_TQ:    b = 8;
      default: b = 12;
    endcase
    return b;
  endfunction

endpackage

FILE: design/jcfp_prep.sv
// Range check, offsets and dividend setup: two register stages.
`timescale 1ns / 1ps
module jcfp_prep import jcfp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [IDX_W-1:0]         joint_index_i,
  input  logic signed [DATA_W-1:0] position_i,
  input  logic signed [DATA_W-1:0] velocity_i,
  input  logic signed [DATA_W-1:0] stiffness_i,
  input  logic signed [DATA_W-1:0] damping_i,
  input  logic signed [DATA_W-1:0] torque_i,
  input  cfg_t                     cfg_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output meta_t                    meta_o,
  output logic [DIV_W-1:0]         rem_o [LANES],
  output logic [OFF_W-1:0]         den_o [LANES]
);

  logic                    va_q, vb_q, ld_a, ld_b;
  logic [IDX_W-1:0]        idx_a_q;
  logic [STATUS_W-1:0]     st_a_q, st_a_d;
  logic signed [OFF_W-1:0] off_a_q [LANES];
  logic signed [OFF_W-1:0] span_a_q [LANES];
  logic signed [OFF_W-1:0] off_a_d [LANES];
  logic signed [OFF_W-1:0] span_a_d [LANES];
  meta_t                   meta_b_q, meta_b_d;
  logic [DIV_W-1:0]        rem_b_q [LANES];
  logic [DIV_W-1:0]        rem_b_d [LANES];
  logic [OFF_W-1:0]        den_b_q [LANES];
  logic [OFF_W-1:0]        den_b_d [LANES];

  assign ld_b       = !vb_q || out_ready_i;
  assign ld_a       = !va_q || ld_b;
  assign in_ready_o = ld_a;

  // stage A: checks and offsets
  always_comb begin
    logic signed [OFF_W-1:0] p, v, kp, kd, t, tk;
    logic signed [OFF_W-1:0] pmin, pmax, vmin, vmax, kpmax, kdmax, tmin, tmax;
    p     = OFF_W'(position_i);
    v     = OFF_W'(velocity_i);
    kp    = OFF_W'(stiffness_i);
    kd    = OFF_W'(damping_i);
    t     = OFF_W'(torque_i);
    pmin  = OFF_W'($signed(cfg_i.pos_min));
    pmax  = OFF_W'($signed(cfg_i.pos_max));
    vmin  = OFF_W'($signed(cfg_i.vel_min));
    vmax  = OFF_W'($signed(cfg_i.vel_max));
    kpmax = $signed({{(OFF_W-GAIN_W){1'b0}}, cfg_i.stiff_max});
    kdmax = $signed({{(OFF_W-GAIN_W){1'b0}}, cfg_i.damp_max});
    tmin  = OFF_W'($signed(cfg_i.torque_min));
    tmax  = OFF_W'($signed(cfg_i.torque_max));
    // slow joints: t*1 against bounds*4, others t*5
    if ({1'b0, joint_index_i} < (IDX_W+1)'(SLOW_JOINTS)) begin
      tk = t;
    end else begin
      tk = (t <<< 2) + t;
    end
    if (p < pmin || p > pmax) begin
      st_a_d = ST_POS;
    end else if (v < vmin || v > vmax) begin
      st_a_d = ST_VEL;
    end else if (kp < 0 || kp > kpmax) begin
      st_a_d = ST_KP;
    end else if (kd < 0 || kd > kdmax) begin
      st_a_d = ST_KD;
    end else if (t < tmin || t > tmax) begin
      st_a_d = ST_TQ;
    end else begin
      st_a_d = ST_OK;
    end
    off_a_d[L_POS]  = p - pmin;
    span_a_d[L_POS] = pmax - pmin;
    off_a_d[L_VEL]  = v - vmin;
    span_a_d[L_VEL] = vmax - vmin;
    off_a_d[L_KP]   = kp;
    span_a_d[L_KP]  = kpmax;
    off_a_d[L_KD]   = kd;
    span_a_d[L_KD]  = kdmax;
    off_a_d[L_TQ]   = tk - (tmin <<< 2);
    span_a_d[L_TQ]  = (tmax - tmin) <<< 2;
  end

  // stage B: dividend = off * (2^bits - 1), torque saturation test
  always_comb begin
    logic [DIV_W-1:0] x;
    meta_b_d.idx    = idx_a_q;
    meta_b_d.status = st_a_q;
    for (int l = 0; l < LANES; l++) begin
      meta_b_d.zero[l] = (off_a_q[l] <= 0) || (span_a_q[l] <= 0);
      x          = DIV_W'(off_a_q[l]);
      rem_b_d[l] = (x << lane_bits(l)) - x;
      den_b_d[l] = span_a_q[l];
    end
    meta_b_d.tsat = rem_b_d[L_TQ] >= (DIV_W'(den_b_d[L_TQ]) << lane_bits(L_TQ));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ld_a) begin
        va_q <= in_valid_i && ({1'b0, joint_index_i} < (IDX_W+1)'(JOINTS));
      end
      if (ld_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_a && in_valid_i) begin
      idx_a_q  <= joint_index_i;
      st_a_q   <= st_a_d;
      off_a_q  <= off_a_d;
      span_a_q <= span_a_d;
    end
    if (ld_b && va_q) begin
      meta_b_q <= meta_b_d;
      rem_b_q  <= rem_b_d;
      den_b_q  <= den_b_d;
    end
  end

  assign out_valid_o = vb_q;
  assign meta_o      = meta_b_q;
  assign rem_o       = rem_b_q;
  assign den_o       = den_b_q;

endmodule

FILE: design/jcfp_div.sv
// Pipelined restoring divider, one quotient bit per stage for all lanes.
`timescale 1ns / 1ps
module jcfp_div import jcfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  meta_t             meta_i,
  input  logic [DIV_W-1:0]  rem_i [LANES],
  input  logic [OFF_W-1:0]  den_i [LANES],
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output meta_t             meta_o,
  output logic [CODE_W-1:0] quo_o [LANES]
);

  logic              v_q    [CODE_W];
  logic              ld     [CODE_W+1];
  meta_t             meta_q [CODE_W];
  logic [DIV_W-1:0]  rem_q  [CODE_W][LANES];
  logic [OFF_W-1:0]  den_q  [CODE_W][LANES];
  logic [CODE_W-1:0] quo_q  [CODE_W][LANES];

  assign ld[CODE_W] = out_ready_i;

  for (genvar s = 0; s < CODE_W; s++) begin : g_stage
    logic              v_in;
    meta_t             meta_in;
    logic [DIV_W-1:0]  rem_in [LANES];
    logic [OFF_W-1:0]  den_in [LANES];
    logic [CODE_W-1:0] quo_in [LANES];
    logic [DIV_W-1:0]  rem_d  [LANES];
    logic [CODE_W-1:0] quo_d  [LANES];

    if (s == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign meta_in = meta_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      for (genvar l = 0; l < LANES; l++) begin : g_zero
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign meta_in = meta_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
    end

    assign ld[s] = !v_q[s] || ld[s+1];

    // try subtracting the divisor at this bit's weight
    always_comb begin
      logic [DIV_W-1:0] sh;
      for (int l = 0; l < LANES; l++) begin
        sh       = DIV_W'(den_in[l]) << (CODE_W - 1 - s);
        rem_d[l] = rem_in[l];
        quo_d[l] = quo_in[l];
        if (rem_in[l] >= sh) begin
          rem_d[l] = rem_in[l] - sh;
          quo_d[l][CODE_W-1-s] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (ld[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[s] && v_in) begin
        meta_q[s] <= meta_in;
        rem_q[s]  <= rem_d;
        den_q[s]  <= den_in;
        quo_q[s]  <= quo_d;
      end
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = v_q[CODE_W-1];
  assign meta_o      = meta_q[CODE_W-1];
  assign quo_o       = quo_q[CODE_W-1];

endmodule

FILE: design/jcfp_pack.sv
// Code clamp, byte packing, check nibble and output register.
`timescale 1ns / 1ps
module jcfp_pack import jcfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  meta_t             meta_i,
  input  logic [CODE_W-1:0] quo_i [LANES],
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  out_data_o
);

  logic             vo_q, ld;
  logic [OUT_W-1:0] data_q, data_d;

  assign ld         = !vo_q || out_ready_i;
  assign in_ready_o = ld;

  always_comb begin
    logic [CODE_W-1:0] c [LANES];
    logic [7:0]        b [8];
    logic [7:0]        x;
    for (int l = 0; l < LANES; l++) begin
      c[l] = meta_i.zero[l] ? '0 : quo_i[l];
    end
    if (!meta_i.zero[L_TQ] && meta_i.tsat) begin
      c[L_TQ] = CODE_W'(8'hFF);
    end
    b[0] = c[L_POS][15:8];
    b[1] = c[L_POS][7:0];
    b[2] = c[L_VEL][11:4];
    b[3] = {c[L_VEL][3:0], c[L_KP][11:8]};
    b[4] = c[L_KP][7:0];
    b[5] = c[L_KD][11:4];
    b[6] = {c[L_KD][3:0], c[L_TQ][7:4]};
    x    = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5] ^ b[6];
    b[7] = {c[L_TQ][3:0], x[3:0]};
    if (meta_i.status != ST_OK) begin
      for (int i = 0; i < 8; i++) begin
        b[i] = '0;
      end
    end
    data_d = {4'b0, meta_i.status, b[7], b[6], b[5], b[4], b[3], b[2], b[1], b[0],
              FRAME_ID_BASE + FRAME_ID_W'(meta_i.idx)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (ld) begin
      vo_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = data_q;

endmodule

FILE: design/mit_joint_command_frame_packer.sv
// An input beat reaches the output beat through the prep, divide and pack registers.
// Throughput: one command beat per cycle; the 16-stage divider pipeline, one
// quotient bit per stage, sets the depth, and each stage holds under backpressure.
// Commands for a joint index of JOINTS or above are taken and dropped.
// Reset (rst_ni low, asynchronous): pipeline empties, bounds take default values.
`timescale 1ns / 1ps
module mit_joint_command_frame_packer import jcfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // joint_index[2:0], position[34:3], velocity[66:35], stiffness[98:67],
  // damping[130:99], torque[162:131], zero fill
  input  logic [IN_W-1:0]      s_axis_tdata_i,
  // frame stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // frame_id[8:0], byte0[16:9] .. byte7[72:65], status[75:73], zero fill
  output logic [OUT_W-1:0]     m_axis_tdata_o,
  // bound registers
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i
);

  cfg_t              cfg_q;
  logic              pv, pr, dv, dr;
  meta_t             p_meta, d_meta;
  logic [DIV_W-1:0]  p_rem [LANES];
  logic [OFF_W-1:0]  p_den [LANES];
  logic [CODE_W-1:0] d_quo [LANES];

  // bound registers; write only while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_min    <= DATA_W'(-819200);
      cfg_q.pos_max    <= DATA_W'(819200);
      cfg_q.vel_min    <= DATA_W'(-2949120);
      cfg_q.vel_max    <= DATA_W'(2949120);
      cfg_q.stiff_max  <= GAIN_W'(32768000);
      cfg_q.damp_max   <= GAIN_W'(327680);
      cfg_q.torque_min <= DATA_W'(-1179648);
      cfg_q.torque_max <= DATA_W'(1179648);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        R_POS_MIN:   cfg_q.pos_min    <= cfg_wdata_i;
        R_POS_MAX:   cfg_q.pos_max    <= cfg_wdata_i;
        R_VEL_MIN:   cfg_q.vel_min    <= cfg_wdata_i;
        R_VEL_MAX:   cfg_q.vel_max    <= cfg_wdata_i;
        R_STIFF_MAX: cfg_q.stiff_max  <= cfg_wdata_i[GAIN_W-1:0];
        R_DAMP_MAX:  cfg_q.damp_max   <= cfg_wdata_i[GAIN_W-1:0];
        R_TQ_MIN:    cfg_q.torque_min <= cfg_wdata_i;
        R_TQ_MAX:    cfg_q.torque_max <= cfg_wdata_i;
        default:     cfg_q            <= cfg_q;
      endcase
    end
  end

  // unpack the beat, check ranges, build dividends
  jcfp_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .joint_index_i (s_axis_tdata_i[2:0]),
    .position_i    ($signed(s_axis_tdata_i[34:3])),
    .velocity_i    ($signed(s_axis_tdata_i[66:35])),
    .stiffness_i   ($signed(s_axis_tdata_i[98:67])),
    .damping_i     ($signed(s_axis_tdata_i[130:99])),
    .torque_i      ($signed(s_axis_tdata_i[162:131])),
    .cfg_i         (cfg_q),
    .out_valid_o   (pv),
    .out_ready_i   (pr),
    .meta_o        (p_meta),
    .rem_o         (p_rem),
    .den_o         (p_den)
  );

  // code = floor(off * (2^bits - 1) / span) for all five lanes at once
  jcfp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pv),
    .in_ready_o  (pr),
    .meta_i      (p_meta),
    .rem_i       (p_rem),
    .den_i       (p_den),
    .out_valid_o (dv),
    .out_ready_i (dr),
    .meta_o      (d_meta),
    .quo_o       (d_quo)
  );

  // clamp, pack bytes, add check nibble; output register parts the sides
  jcfp_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv),
    .in_ready_o  (dr),
    .meta_i      (d_meta),
    .quo_i       (d_quo),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
